### src/ledrs_pkg.sv
// ----------------------------------------------------------------------------
// LED matrix row-scan driver package
// Shared types, codes and helper functions for the row-scan driver.
// ----------------------------------------------------------------------------
package ledrs_pkg;

  // Request operations.
  localparam logic OP_WRITE = 1'b0;
  localparam logic OP_TICK  = 1'b1;

  // Configuration register indexes.
  localparam logic [2:0] CFG_PANEL_WIDTH    = 3'd0;
  localparam logic [2:0] CFG_SCAN_ROWS      = 3'd1;
  localparam logic [2:0] CFG_SCAN_RATE_CODE = 3'd2;
  localparam logic [2:0] CFG_DISPLAY_ENABLE = 3'd3;
  localparam logic [2:0] CFG_ROW_HOLD_TICKS = 3'd4;

  // Configuration reset values.
  localparam logic [6:0] RST_PANEL_WIDTH    = 7'd64;
  localparam logic [5:0] RST_SCAN_ROWS      = 6'd16;
  localparam logic [1:0] RST_SCAN_RATE_CODE = 2'd2;
  localparam logic       RST_DISPLAY_ENABLE = 1'b1;
  localparam logic [7:0] RST_ROW_HOLD_TICKS = 8'd10;

  // Scan sequencer phases.
  localparam logic [2:0] PH_ROW   = 3'd0;
  localparam logic [2:0] PH_DATA  = 3'd1;
  localparam logic [2:0] PH_CLOCK = 3'd2;
  localparam logic [2:0] PH_LATCH = 3'd3;
  localparam logic [2:0] PH_HOLD  = 3'd4;

  typedef struct packed {
    logic        operation;
    logic [5:0]  pixel_x;
    logic [5:0]  pixel_y;
    logic [15:0] pixel_color;
  } req_t;

  typedef struct packed {
    logic       upper_red;
    logic       upper_green;
    logic       upper_blue;
    logic       lower_red;
    logic       lower_green;
    logic       lower_blue;
    logic       shift_clock;
    logic       latch;
    logic       output_enable_n;
    logic [4:0] row_address;
  } rsp_t;

  typedef struct packed {
    logic [2:0] index;
    logic [7:0] data;
  } cfg_t;

  // Control pin levels carried alongside each request.
  typedef struct packed {
    logic [4:0] row_address;
    logic       output_enable_n;
    logic       latch;
    logic       shift_clock;
  } ctrl_t;

  // Nonzero flags of the RGB565 channels: bit 0 red, bit 1 green, bit 2 blue.
  function automatic logic [2:0] rgb_flags(input logic [15:0] color);
    logic [2:0] f;
    f[0] = |color[15:11];
    f[1] = |color[10:5];
    f[2] = |color[4:0];
    return f;
  endfunction

  // Row address mask for the scan-rate code: two to five address bits.
  function automatic logic [4:0] addr_mask(input logic [1:0] code);
    logic [4:0] m;
    unique case (code)
      2'd0:    m = 5'h03;
      2'd1:    m = 5'h07;
      2'd2:    m = 5'h0F;
      default: m = 5'h1F;
    endcase
    return m;
  endfunction

endpackage

### src/ledrs_ifs.sv
// ----------------------------------------------------------------------------
// LED matrix row-scan driver channels
// Valid/ready channels for requests, results and configuration writes.
// ----------------------------------------------------------------------------
interface ledrs_req_if;
  logic              valid;
  logic              ready;
  ledrs_pkg::req_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ledrs_rsp_if;
  logic              valid;
  logic              ready;
  ledrs_pkg::rsp_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

interface ledrs_cfg_if;
  logic              valid;
  logic              ready;
  ledrs_pkg::cfg_t   payload;
  modport source (output valid, output payload, input ready);
  modport sink (input valid, input payload, output ready);
endinterface

### src/led_matrix_row_scan_driver.sv
// A result is offered once its request has passed through stage one and the output register.
// Throughput: one request per cycle while stage one can move on and no clearing sweep runs.
// After reset the whole framebuffer of MAX_WIDTH*MAX_HEIGHT entries (4096 by default)
// is swept to zero, one pixel per cycle; no request is taken meanwhile.
// Configuration writes are taken at any time, including during that sweep.
// ----------------------------------------------------------------------------
// LED matrix row-scan driver
// Scan sequencer for a two-half LED panel with a flag framebuffer in RAM.
// ----------------------------------------------------------------------------
module led_matrix_row_scan_driver #(
  parameter int MAX_WIDTH  = 64,
  parameter int MAX_HEIGHT = 64
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  ledrs_req_if.sink   req_i,
  ledrs_rsp_if.source rsp_o,
  ledrs_cfg_if.sink   cfg_i
);

  import ledrs_pkg::*;

  localparam int STORE = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(STORE);
  localparam int HALF  = MAX_HEIGHT / 2;
  localparam int RW    = $clog2(HALF);
  localparam int YW    = $clog2(MAX_HEIGHT);
  localparam int CW    = $clog2(MAX_WIDTH);
  localparam int EW    = $clog2(MAX_WIDTH + 1);
  localparam int ERW   = $clog2(HALF + 1);

  // --------------------------------------------------------------------------
  // Configuration registers. The port never pushes back.
  // --------------------------------------------------------------------------
  logic [6:0] panel_width_q;
  logic [5:0] half_rows_q;
  logic [1:0] addr_code_q;
  logic       display_enable_q;
  logic [7:0] row_hold_ticks_q;

  assign cfg_i.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      panel_width_q    <= RST_PANEL_WIDTH;
      half_rows_q      <= RST_SCAN_ROWS;
      addr_code_q      <= RST_SCAN_RATE_CODE;
      display_enable_q <= RST_DISPLAY_ENABLE;
      row_hold_ticks_q <= RST_ROW_HOLD_TICKS;
    end else if (cfg_i.valid) begin
      unique case (cfg_i.payload.index)
        CFG_PANEL_WIDTH:    panel_width_q    <= cfg_i.payload.data[6:0];
        CFG_SCAN_ROWS:      half_rows_q      <= cfg_i.payload.data[5:0];
        CFG_SCAN_RATE_CODE: addr_code_q      <= cfg_i.payload.data[1:0];
        CFG_DISPLAY_ENABLE: display_enable_q <= cfg_i.payload.data[0];
        CFG_ROW_HOLD_TICKS: row_hold_ticks_q <= cfg_i.payload.data;
        default: ;
      endcase
    end
  end

  // Effective panel size: the width is capped at the framebuffer width, the
  // row count is kept between one and half the framebuffer height.
  logic [EW-1:0]  eff_width;
  logic [ERW-1:0] eff_rows;

  always_comb begin
    if (8'(panel_width_q) > 8'(MAX_WIDTH)) begin
      eff_width = EW'(MAX_WIDTH);
    end else begin
      eff_width = EW'(panel_width_q);
    end
    if (half_rows_q == 6'd0) begin
      eff_rows = ERW'(1);
    end else if (8'(half_rows_q) > 8'(HALF)) begin
      eff_rows = ERW'(HALF);
    end else begin
      eff_rows = ERW'(half_rows_q);
    end
  end

  // --------------------------------------------------------------------------
  // Framebuffer clearing sweep after reset.
  // --------------------------------------------------------------------------
  logic          clearing_q;
  logic [AW-1:0] clr_addr_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clearing_q <= 1'b1;
      clr_addr_q <= '0;
    end else if (clearing_q) begin
      clr_addr_q <= clr_addr_q + 1'b1;
      if (clr_addr_q == AW'(STORE - 1)) begin
        clearing_q <= 1'b0;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Handshake. Stage one sits between the sequencer and the output register,
  // so a new request is taken while a finished result still waits.
  // --------------------------------------------------------------------------
  logic s1_valid_q;
  logic out_valid_q;
  logic s1_move;
  logic req_acc;

  assign s1_move     = !out_valid_q || rsp_o.ready;
  assign req_i.ready = !clearing_q && (!s1_valid_q || s1_move);
  assign req_acc     = req_i.valid && req_i.ready;

  // --------------------------------------------------------------------------
  // Scan sequencer. It advances in the cycle a tick request is accepted and
  // works out the control pins; the colour bits come from the framebuffer
  // in the cycle after.
  // --------------------------------------------------------------------------
  logic [2:0]    phase_q, phase_d;
  logic [RW-1:0] row_q, row_d;
  logic [CW-1:0] col_q, col_d;
  logic [7:0]    hold_q, hold_d;
  ctrl_t         pins_q, pins_d;

  logic          tick_acc;
  logic          rd_en;
  logic [7:0]    hold_dec;
  logic [RW-1:0] row_start;
  logic [RW-1:0] row_next;

  assign tick_acc = req_acc && (req_i.payload.operation == OP_TICK);
  assign rd_en    = tick_acc && (phase_q == PH_DATA);
  assign hold_dec = hold_q - 8'd1;

  // A row counter left beyond a shrunk row count restarts at row zero.
  assign row_start = (8'(row_q) >= 8'(eff_rows)) ? '0 : row_q;
  assign row_next  = (8'(row_q) + 8'd1 >= 8'(eff_rows)) ? '0 : RW'(row_q + 1'b1);

  always_comb begin
    phase_d = phase_q;
    row_d   = row_q;
    col_d   = col_q;
    hold_d  = hold_q;
    pins_d  = pins_q;
    if (tick_acc) begin
      unique case (phase_q)
        PH_DATA: begin
          pins_d.shift_clock = 1'b0;
          pins_d.latch       = 1'b0;
          phase_d            = PH_CLOCK;
        end
        PH_CLOCK: begin
          pins_d.shift_clock = 1'b1;
          if (8'(col_q) + 8'd1 >= 8'(eff_width)) begin
            phase_d = PH_LATCH;
          end else begin
            col_d   = col_q + 1'b1;
            phase_d = PH_DATA;
          end
        end
        PH_LATCH: begin
          pins_d.shift_clock = 1'b0;
          pins_d.latch       = 1'b1;
          if (display_enable_q && (row_hold_ticks_q != 8'd0)) begin
            hold_d  = row_hold_ticks_q;
            phase_d = PH_HOLD;
          end else begin
            row_d   = row_next;
            phase_d = PH_ROW;
          end
        end
        PH_HOLD: begin
          // Disabling the display darkens the panel at once, but the hold
          // still counts out in full.
          pins_d.latch           = 1'b0;
          pins_d.output_enable_n = !display_enable_q;
          hold_d                 = hold_dec;
          if (hold_dec == 8'd0) begin
            row_d   = row_next;
            phase_d = PH_ROW;
          end
        end
        default: begin
          // Row start, also taken for any phase code without a meaning.
          row_d                  = row_start;
          pins_d.output_enable_n = 1'b1;
          pins_d.latch           = 1'b0;
          pins_d.shift_clock     = 1'b0;
          pins_d.row_address     = 5'(row_start) & addr_mask(addr_code_q);
          col_d                  = '0;
          phase_d                = (eff_width == '0) ? PH_LATCH : PH_DATA;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_ROW;
      row_q   <= '0;
      col_q   <= '0;
      hold_q  <= '0;
      pins_q  <= '{row_address: 5'd0, output_enable_n: 1'b1, latch: 1'b0,
                   shift_clock: 1'b0};
    end else begin
      phase_q <= phase_d;
      row_q   <= row_d;
      col_q   <= col_d;
      hold_q  <= hold_d;
      pins_q  <= pins_d;
    end
  end

  // --------------------------------------------------------------------------
  // Framebuffer. Two copies take every write, so the upper and the lower
  // pixel of a column are read in the same cycle. A write lands at the edge
  // that accepts it, so a tick right behind it already reads the new flags.
  // --------------------------------------------------------------------------
  logic          pix_in_panel;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [2:0]    ram_wdata;
  logic [AW-1:0] rd_addr_up;
  logic [AW-1:0] rd_addr_lo;
  logic [YW-1:0] lower_row;
  logic [2:0]    up_flags;
  logic [2:0]    lo_flags;

  assign pix_in_panel = (8'(req_i.payload.pixel_x) < 8'(eff_width)) &&
                        (8'(req_i.payload.pixel_y) < (8'(eff_rows) << 1));

  always_comb begin
    if (clearing_q) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_q;
      ram_wdata = '0;
    end else begin
      ram_we    = req_acc && (req_i.payload.operation == OP_WRITE) && pix_in_panel;
      ram_waddr = AW'(AW'(req_i.payload.pixel_y) * AW'(MAX_WIDTH) +
                      AW'(req_i.payload.pixel_x));
      ram_wdata = rgb_flags(req_i.payload.pixel_color);
    end
  end

  assign lower_row  = YW'(row_q) + YW'(eff_rows);
  assign rd_addr_up = AW'(AW'(row_q) * AW'(MAX_WIDTH) + AW'(col_q));
  assign rd_addr_lo = AW'(AW'(lower_row) * AW'(MAX_WIDTH) + AW'(col_q));

  ledrs_ram #(
    .WIDTH (3),
    .DEPTH (STORE)
  ) u_ram_upper (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr_up),
    .rdata_o (up_flags)
  );

  ledrs_ram #(
    .WIDTH (3),
    .DEPTH (STORE)
  ) u_ram_lower (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (rd_en),
    .raddr_i (rd_addr_lo),
    .rdata_o (lo_flags)
  );

  // --------------------------------------------------------------------------
  // Stage one: merge the framebuffer flags into the pin levels. Colour pins
  // keep their last levels on every step other than a column data step. The
  // RAM read data holds while stage one stalls, as no new read is issued.
  // --------------------------------------------------------------------------
  ctrl_t      s1_ctrl_q;
  logic       s1_is_data_q;
  logic [5:0] colour_q;
  logic [5:0] s1_colour;
  rsp_t       out_q, out_d;

  assign s1_colour = s1_is_data_q ? {lo_flags, up_flags} : colour_q;

  always_comb begin
    out_d.upper_red       = s1_colour[0];
    out_d.upper_green     = s1_colour[1];
    out_d.upper_blue      = s1_colour[2];
    out_d.lower_red       = s1_colour[3];
    out_d.lower_green     = s1_colour[4];
    out_d.lower_blue      = s1_colour[5];
    out_d.shift_clock     = s1_ctrl_q.shift_clock;
    out_d.latch           = s1_ctrl_q.latch;
    out_d.output_enable_n = s1_ctrl_q.output_enable_n;
    out_d.row_address     = s1_ctrl_q.row_address;
  end

  // Stage one fills whenever it is empty, even while the output register
  // stalls; it only holds when it is full and cannot move on.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      colour_q    <= '0;
    end else begin
      if (s1_move || !s1_valid_q) begin
        s1_valid_q <= req_acc;
      end
      if (s1_move) begin
        out_valid_q <= s1_valid_q;
        if (s1_valid_q) begin
          colour_q <= s1_colour;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (req_acc) begin
      s1_ctrl_q    <= pins_d;
      s1_is_data_q <= rd_en;
    end
    if (s1_move && s1_valid_q) begin
      out_q <= out_d;
    end
  end

  assign rsp_o.valid   = out_valid_q;
  assign rsp_o.payload = out_q;

  // --------------------------------------------------------------------------
  // Assertions.
  // --------------------------------------------------------------------------
  a_no_req_while_clearing: assert property (
    @(posedge clk_i) disable iff (!rst_ni) clearing_q |-> !req_acc
  ) else $error("request accepted during the framebuffer sweep");

  a_read_in_range: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    rd_en |-> (32'(rd_addr_up) < STORE) && (32'(rd_addr_lo) < STORE)
  ) else $error("framebuffer read outside the store");

  a_hold_nonzero: assert property (
    @(posedge clk_i) disable iff (!rst_ni) (phase_q == PH_HOLD) |-> (hold_q != 8'd0)
  ) else $error("hold phase with an exhausted counter");

  a_clock_latch_apart: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    rsp_o.valid |-> !(rsp_o.payload.shift_clock && rsp_o.payload.latch)
  ) else $error("shift clock and latch high together");

  a_stage_held: assert property (
    @(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && !s1_move) |=> (s1_valid_q && $stable(s1_ctrl_q))
  ) else $error("stalled result lost from stage one");

endmodule

### src/ledrs_ram.sv
// ----------------------------------------------------------------------------
// Generic single-port-write RAM
// One write port and one read port with a registered read.
// ----------------------------------------------------------------------------
module ledrs_ram #(
  parameter int WIDTH = 3,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule
